[src/lbc_pkg.sv]
// Package for the LRU block buffer cache.
// Holds sizes, field types, operation and result codes, and the cell types.
// No dependencies.
package lbc_pkg;

   localparam int ENTRIES    = 16;
   localparam int BLOCK_BITS = 24;

   localparam int POS_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int OP_W      = 2;
   localparam int BLK_W     = 24;
   localparam int BUF_IDX_W = 4;
   localparam int KIND_W    = 3;

   typedef logic [OP_W-1:0]       op_type;
   typedef logic [BLK_W-1:0]      blkno_type;
   typedef logic [BUF_IDX_W-1:0]  bufidx_type;
   typedef logic [KIND_W-1:0]     kind_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [BLOCK_BITS-1:0] tag_type;

   localparam op_type OP_GET    = 2'd0;
   localparam op_type OP_REL_WT = 2'd1;
   localparam op_type OP_REL_DL = 2'd2;
   localparam op_type OP_FLUSH  = 2'd3;

   localparam kind_type KIND_GRANT  = 3'd0;
   localparam kind_type KIND_READ   = 3'd1;
   localparam kind_type KIND_WRITE  = 3'd2;
   localparam kind_type KIND_NOFREE = 3'd3;
   localparam kind_type KIND_DONE   = 3'd4;

   localparam pos_type LAST_POS = pos_type'(ENTRIES - 1);

   typedef struct packed {
      pos_type idx;
      tag_type tag;
      logic    mapped;
      logic    dirty;
      logic    held;
   } entry_type;

   typedef struct packed {
      logic      en;
      pos_type   src;
      pos_type   dst;
      entry_type ent;
   } move_type;

   typedef struct packed {
      logic    en;
      pos_type idx;
   } flush_type;

endpackage

[src/lbc_req_if.sv]
// Request channel of the LRU block buffer cache.
// Depends on lbc_pkg for the field types.
interface lbc_req_if
   import lbc_pkg::*;
   ();
   logic       valid;
   logic       ready;
   op_type     op;
   blkno_type  block_num;
   bufidx_type buffer_index;

   modport source (output valid, op, block_num, buffer_index, input ready);
   modport sink   (input valid, op, block_num, buffer_index, output ready);
endinterface

[src/lbc_rsp_if.sv]
// Result channel of the LRU block buffer cache.
// Depends on lbc_pkg for the field types.
interface lbc_rsp_if
   import lbc_pkg::*;
   ();
   logic       valid;
   logic       ready;
   kind_type   kind;
   bufidx_type buffer_index_res;
   blkno_type  block_num_res;
   logic       hit;
   logic       bad_release;
   logic       last;

   modport source (output valid, kind, buffer_index_res, block_num_res, hit, bad_release, last,
                   input ready);
   modport sink   (input valid, kind, buffer_index_res, block_num_res, hit, bad_release, last,
                   output ready);
endinterface

[src/lbc_cell.sv]
// One position of the buffer list: holds one buffer entry and its tag compare.
// Depends on lbc_pkg.
module lbc_cell
   import lbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  pos_type   cell_pos,
   input  entry_type left_ent,
   input  entry_type right_ent,
   input  move_type  move,
   input  flush_type flush,
   input  tag_type   key,
   output entry_type ent,
   output logic      tag_hit
);

   pos_type idx_ff, idx_in;
   tag_type tag_ff, tag_in;
   logic    mapped_ff, mapped_in;
   logic    dirty_ff, dirty_in;
   logic    held_ff, held_in;

   logic      take_bcast;
   logic      take_right;
   logic      take_left;
   entry_type next_ent;

   assign ent     = '{idx: idx_ff, tag: tag_ff, mapped: mapped_ff, dirty: dirty_ff,
                      held: held_ff};
   assign tag_hit = mapped_ff && (tag_ff == key);

   always_comb begin
      take_bcast = move.en && (cell_pos == move.dst);
      take_right = move.en && (move.dst > move.src) && (cell_pos >= move.src)
                   && (cell_pos < move.dst);
      take_left  = move.en && (move.dst < move.src) && (cell_pos > move.dst)
                   && (cell_pos <= move.src);
      if (take_bcast) begin
         next_ent = move.ent;
      end else if (take_right) begin
         next_ent = right_ent;
      end else if (take_left) begin
         next_ent = left_ent;
      end else begin
         next_ent = ent;
      end
      if (flush.en && (ent.idx == flush.idx)) begin
         next_ent.dirty = 1'b0;
      end
      idx_in    = next_ent.idx;
      tag_in    = next_ent.tag;
      mapped_in = next_ent.mapped;
      dirty_in  = next_ent.dirty;
      held_in   = next_ent.held;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= cell_pos;
         mapped_ff <= 1'b0;
         dirty_ff  <= 1'b0;
         held_ff   <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         mapped_ff <= mapped_in;
         dirty_ff  <= dirty_in;
         held_ff   <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

endmodule

[src/lru_block_buffer_cache.sv]
// LRU block buffer cache with delayed write: top level with the sequencer.
// Depends on lbc_pkg, lbc_req_if, lbc_rsp_if and lbc_cell.
//
// Use: req_ch carries op, block_num and buffer_index; an item is taken when
// valid and ready are both high. rsp_ch carries the results of that item, one
// per accepted transfer, the final one marked by last. A get answers with an
// optional write-back, an optional read request and a grant, or a single
// no-free-buffer result; a release answers with an optional write and done;
// a flush answers with one write per dirty entry in index order and done.
// Timing: req_ch.ready is high only while no item is in work. An accepted item
// is first registered; the sequencer then fills the single output register
// with one result per cycle while the receiver does not stall.
// The entries sit in a row of cells ordered free queue first (oldest first),
// held entries after it; a lookup compares all tags in parallel.
// Reset: all entries are free, unmapped and clean, in index order; tags are
// undefined until written. When rsp_ch stalls, the pending result holds and
// the sequencer waits; no result is dropped.
module lru_block_buffer_cache
   import lbc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   lbc_req_if.sink   req_ch,
   lbc_rsp_if.source rsp_ch
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOK  = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_FIN   = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0] state_ff, state_in;
   cnt_type    count_ff, count_in;

   op_type     op_ff, op_in;
   tag_type    key_ff, key_in;
   bufidx_type idx_ff, idx_in;

   bufidx_type r_idx_ff, r_idx_in;
   tag_type    r_blk_ff, r_blk_in;
   logic       r_hit_ff, r_hit_in;
   kind_type   r_kind_ff, r_kind_in;

   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   rsp_kind_ff, rsp_kind_in;
   bufidx_type rsp_idx_ff, rsp_idx_in;
   blkno_type  rsp_blk_ff, rsp_blk_in;
   logic       rsp_hit_ff, rsp_hit_in;
   logic       rsp_bad_ff, rsp_bad_in;
   logic       rsp_last_ff, rsp_last_in;

   entry_type           ents [ENTRIES];
   entry_type           left_ents [ENTRIES];
   entry_type           right_ents [ENTRIES];
   logic [ENTRIES-1:0]  tag_hits;
   logic [ENTRIES-1:0]  rel_match;
   logic [ENTRIES-1:0]  sel_oh;
   logic [ENTRIES-1:0]  dirty_vec;
   move_type            move;
   flush_type           flush;

   logic      out_load;
   logic      hit_any;
   logic      rel_any;
   pos_type   sel_pos;
   entry_type sel_ent;
   entry_type new_ent;
   logic      fl_any;
   pos_type   fl_idx;
   tag_type   fl_tag;

   logic       e_valid;
   kind_type   e_kind;
   bufidx_type e_idx;
   tag_type    e_blk;
   logic       e_hit;
   logic       e_bad;
   logic       e_last;

   always_comb begin
      for (int j = 0; j < ENTRIES; j++) begin
         left_ents[j]  = (j == 0) ? ents[j] : ents[(j == 0) ? 0 : j - 1];
         right_ents[j] = (j == ENTRIES - 1) ? ents[j] : ents[(j == ENTRIES - 1) ? j : j + 1];
      end
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lbc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_pos  (pos_type'(g)),
         .left_ent  (left_ents[g]),
         .right_ent (right_ents[g]),
         .move      (move),
         .flush     (flush),
         .key       (key_ff),
         .ent       (ents[g]),
         .tag_hit   (tag_hits[g])
      );
   end

   // Lookup: pick the entry this item works on, as a one-hot position.
   always_comb begin
      for (int j = 0; j < ENTRIES; j++) begin
         rel_match[j] = (32'(ents[j].idx) == 32'(idx_ff));
      end
      hit_any = |tag_hits;
      rel_any = |rel_match;
      if (op_ff == OP_GET) begin
         sel_oh = hit_any ? tag_hits : ENTRIES'(1);
      end else begin
         sel_oh = rel_match;
      end
      sel_pos = '0;
      sel_ent = '0;
      for (int j = 0; j < ENTRIES; j++) begin
         if (sel_oh[j]) begin
            sel_pos = sel_pos | pos_type'(j);
         end
         sel_ent = entry_type'(sel_ent | (sel_oh[j] ? ents[j] : entry_type'('0)));
      end
   end

   // Flush: lowest entry index that is dirty, and its tag.
   always_comb begin
      dirty_vec = '0;
      for (int j = 0; j < ENTRIES; j++) begin
         if (ents[j].dirty) begin
            dirty_vec[ents[j].idx] = 1'b1;
         end
      end
      fl_any = |dirty_vec;
      fl_idx = '0;
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (dirty_vec[k]) begin
            fl_idx = pos_type'(k);
         end
      end
      fl_tag = '0;
      for (int j = 0; j < ENTRIES; j++) begin
         if (ents[j].dirty && (ents[j].idx == fl_idx)) begin
            fl_tag = fl_tag | ents[j].tag;
         end
      end
   end

   assign out_load = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      r_idx_in  = r_idx_ff;
      r_blk_in  = r_blk_ff;
      r_hit_in  = r_hit_ff;
      r_kind_in = r_kind_ff;
      move      = '0;
      flush     = '0;
      new_ent   = sel_ent;
      e_valid   = 1'b0;
      e_kind    = KIND_DONE;
      e_idx     = '0;
      e_blk     = '0;
      e_hit     = 1'b0;
      e_bad     = 1'b0;
      e_last    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in  = req_ch.op;
               key_in = tag_type'(req_ch.block_num);
               idx_in = req_ch.buffer_index;
               state_in = (req_ch.op == OP_FLUSH) ? S_FLUSH : S_LOOK;
            end
         end
         S_LOOK: begin
            if (out_load) begin
               e_valid = 1'b1;
               if (op_ff == OP_GET) begin
                  r_idx_in  = bufidx_type'(sel_ent.idx);
                  r_blk_in  = key_ff;
                  r_hit_in  = hit_any;
                  r_kind_in = KIND_GRANT;
                  e_idx     = bufidx_type'(sel_ent.idx);
                  e_blk     = key_ff;
                  e_hit     = hit_any;
                  if (hit_any) begin
                     if (!sel_ent.held) begin
                        new_ent.held = 1'b1;
                        move     = '{en: 1'b1, src: sel_pos, dst: LAST_POS, ent: new_ent};
                        count_in = cnt_type'(count_ff - 1'b1);
                     end
                     if (sel_ent.dirty) begin
                        e_kind   = KIND_GRANT;
                        e_last   = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        e_kind   = KIND_READ;
                        state_in = S_FIN;
                     end
                  end else if (count_ff == '0) begin
                     e_kind   = KIND_NOFREE;
                     e_idx    = '0;
                     e_blk    = '0;
                     e_last   = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     new_ent.tag    = key_ff;
                     new_ent.mapped = 1'b1;
                     new_ent.dirty  = 1'b0;
                     new_ent.held   = 1'b1;
                     move     = '{en: 1'b1, src: sel_pos, dst: LAST_POS, ent: new_ent};
                     count_in = cnt_type'(count_ff - 1'b1);
                     if (sel_ent.mapped && sel_ent.dirty) begin
                        e_kind   = KIND_WRITE;
                        e_blk    = sel_ent.tag;
                        state_in = S_RD;
                     end else begin
                        e_kind   = KIND_READ;
                        state_in = S_FIN;
                     end
                  end
               end else if (!rel_any || !sel_ent.held) begin
                  e_kind   = KIND_DONE;
                  e_idx    = idx_ff;
                  e_bad    = 1'b1;
                  e_last   = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  new_ent.held  = 1'b0;
                  new_ent.dirty = (op_ff == OP_REL_DL);
                  move      = '{en: 1'b1, src: sel_pos, dst: pos_type'(count_ff), ent: new_ent};
                  count_in  = cnt_type'(count_ff + 1'b1);
                  r_idx_in  = idx_ff;
                  r_blk_in  = sel_ent.tag;
                  r_hit_in  = 1'b0;
                  r_kind_in = KIND_DONE;
                  e_idx     = idx_ff;
                  e_blk     = sel_ent.tag;
                  if (op_ff == OP_REL_WT) begin
                     e_kind   = KIND_WRITE;
                     state_in = S_FIN;
                  end else begin
                     e_kind   = KIND_DONE;
                     e_last   = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_RD: begin
            if (out_load) begin
               e_valid  = 1'b1;
               e_kind   = KIND_READ;
               e_idx    = r_idx_ff;
               e_blk    = r_blk_ff;
               e_hit    = r_hit_ff;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_load) begin
               e_valid  = 1'b1;
               e_kind   = r_kind_ff;
               e_idx    = r_idx_ff;
               e_blk    = r_blk_ff;
               e_hit    = r_hit_ff;
               e_last   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (out_load) begin
               e_valid = 1'b1;
               if (fl_any) begin
                  e_kind = KIND_WRITE;
                  e_idx  = bufidx_type'(fl_idx);
                  e_blk  = fl_tag;
                  flush  = '{en: 1'b1, idx: fl_idx};
               end else begin
                  e_kind   = KIND_DONE;
                  e_last   = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_blk_in   = rsp_blk_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_last_in  = rsp_last_ff;
      if (e_valid) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = e_kind;
         rsp_idx_in   = e_idx;
         rsp_blk_in   = blkno_type'(e_blk);
         rsp_hit_in   = e_hit;
         rsp_bad_in   = e_bad;
         rsp_last_in  = e_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= cnt_type'(ENTRIES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      r_idx_ff    <= r_idx_in;
      r_blk_ff    <= r_blk_in;
      r_hit_ff    <= r_hit_in;
      r_kind_ff   <= r_kind_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_blk_ff  <= rsp_blk_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ch.ready            = (state_ff == S_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.kind             = rsp_kind_ff;
   assign rsp_ch.buffer_index_res = rsp_idx_ff;
   assign rsp_ch.block_num_res    = rsp_blk_ff;
   assign rsp_ch.hit              = rsp_hit_ff;
   assign rsp_ch.bad_release      = rsp_bad_ff;
   assign rsp_ch.last             = rsp_last_ff;

endmodule

[src/lbc_checker.sv]
// Port-level checks for the LRU block buffer cache, bound to the top level.
// Depends on lbc_pkg and lru_block_buffer_cache.
module lbc_checker
   import lbc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input kind_type   rsp_kind,
   input bufidx_type rsp_buffer_index_res,
   input blkno_type  rsp_block_num_res,
   input logic       rsp_hit,
   input logic       rsp_bad_release,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_buffer_index_res) && $stable(rsp_block_num_res) && $stable(rsp_last))
      else $error("Stalled result changed.");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Second item accepted while one is in work.");

   a_single_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_NOFREE || rsp_bad_release) |-> rsp_last)
      else $error("Single-result answer not marked last.");

   a_bad_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_release |-> rsp_kind == KIND_DONE && rsp_block_num_res == '0)
      else $error("Refused release gave a wrong result.");

   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> (rsp_kind == KIND_GRANT || rsp_kind == KIND_READ))
      else $error("Hit flag on a result that is not part of a get.");

endmodule

bind lru_block_buffer_cache lbc_checker u_lbc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_ch.valid),
   .req_ready            (req_ch.ready),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_kind             (rsp_ch.kind),
   .rsp_buffer_index_res (rsp_ch.buffer_index_res),
   .rsp_block_num_res    (rsp_ch.block_num_res),
   .rsp_hit              (rsp_ch.hit),
   .rsp_bad_release      (rsp_ch.bad_release),
   .rsp_last             (rsp_ch.last)
);
